@@ hdl/bhed_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and a helper function of the backslash hex escape decoder.
package bhed_pkg;

   // Field widths fixed by the interface definition.
   localparam int CHAR_W = 8;
   localparam int CFG_W  = 12;
   localparam int LEN_W  = 13;
   localparam int NIB_W  = 4;

   // Default width of the decoded length counter.
   localparam int COUNT_BITS_DEF = 13;

   // Reset value of the maximum length register.
   localparam logic [CFG_W-1:0] MAX_LEN_RESET = 12'd128;

   // Character codes.
   localparam logic [CHAR_W-1:0] BACKSLASH = 8'h5C;

   // Item kinds.
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Escape phase codes.
   localparam logic [1:0] PH_TEXT = 2'd0;
   localparam logic [1:0] PH_ESC  = 2'd1;
   localparam logic [1:0] PH_HEX  = 2'd2;

   // Hex digit decode result: valid flag and nibble value.
   typedef struct packed {
      logic             ok;
      logic [NIB_W-1:0] nib;
   } hex_digit_type;

   // Decode one character as a hex digit in either case.
   function automatic hex_digit_type hex_decode(input logic [CHAR_W-1:0] c);
      hex_digit_type r;
      logic [CHAR_W-1:0] d;
      r = '0;
      d = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d     = c - 8'h30;
         r.ok  = 1'b1;
         r.nib = d[NIB_W-1:0];
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d     = c - 8'h37;
         r.ok  = 1'b1;
         r.nib = d[NIB_W-1:0];
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d     = c - 8'h57;
         r.ok  = 1'b1;
         r.nib = d[NIB_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/bhed_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for decoder requests and responses.
interface bhed_req_if;
   import bhed_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output kind, output char_code, input ready);
   modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface bhed_rsp_if;
   import bhed_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_byte;
   logic              byte_valid;
   logic              done_res;
   logic              status;
   logic [LEN_W-1:0]  decoded_length;

   modport source (output valid, output out_byte, output byte_valid, output done_res,
                   output status, output decoded_length, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input done_res,
                   input status, input decoded_length, output ready);
endinterface

@@ hdl/backslash_hex_escape_decoder.sv @@
`timescale 1ns / 1ps
// A request transfer is registered in the input stage, then decoded into the response
// register once that register is free; a response-side stall holds it in the input stage.
// Throughput: one request per cycle unless the response side stalls, set by the single decode
// step between the two registers; characters with no response leave the response side alone.
// Reset: synchronous, active high; clears escape state, count, error flag and valid flags,
// and sets the maximum length to 128.
module backslash_hex_escape_decoder #(
   parameter int COUNT_BITS = bhed_pkg::COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   bhed_req_if.sink                   req_ch,
   bhed_rsp_if.source                 rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [bhed_pkg::CFG_W-1:0] csr_wr_data
);
   import bhed_pkg::*;

   // Common width for count and limit comparisons.
   localparam int WIDE_W = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 1;
   localparam logic [WIDE_W-1:0] CNT_MASK = WIDE_W'((64'd1 << COUNT_BITS) - 64'd1);

   // Configuration register.
   logic [CFG_W-1:0] max_len_ff;

   // Input stage.
   logic              in_valid_ff, in_valid_in;
   logic              in_kind_ff;
   logic [CHAR_W-1:0] in_char_ff;

   // Decoder state.
   logic [1:0]            phase_ff, phase_in;
   logic [NIB_W-1:0]      nib_ff, nib_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  err_ff, err_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_bv_ff, rsp_bv_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic              out_free;
   logic              proc;
   logic              has_res;
   hex_digit_type     hex;
   logic [WIDE_W-1:0] cnt_wide;
   logic [WIDE_W-1:0] limit_raw;
   logic [WIDE_W-1:0] limit;
   logic [COUNT_BITS-1:0] count_inc;
   logic              bad_end;

   // Handshake: the input stage moves on whenever the response register is free.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign proc         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign in_valid_in  = req_ch.valid ? 1'b1 : (in_valid_ff && !out_free);

   // Saturating count limit and the end-of-string length check.
   assign cnt_wide  = WIDE_W'(count_ff);
   assign limit_raw = WIDE_W'(max_len_ff) + WIDE_W'(1);
   assign limit     = (limit_raw > CNT_MASK) ? CNT_MASK : limit_raw;
   assign count_inc = (cnt_wide < limit) ? count_ff + COUNT_BITS'(1) : count_ff;
   assign bad_end   = err_ff || (phase_ff != PH_TEXT) || (cnt_wide > WIDE_W'(max_len_ff));
   assign hex       = hex_decode(in_char_ff);

   // Decode one character or end item against the current escape state.
   always_comb begin
      phase_in      = phase_ff;
      nib_in        = nib_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      has_res       = 1'b0;
      rsp_byte_in   = '0;
      rsp_bv_in     = 1'b0;
      rsp_done_in   = 1'b0;
      rsp_status_in = 1'b0;
      rsp_len_in    = '0;
      if (in_kind_ff == KIND_END) begin
         has_res       = 1'b1;
         rsp_done_in   = 1'b1;
         rsp_status_in = bad_end;
         rsp_len_in    = bad_end ? '0 : cnt_wide[LEN_W-1:0];
         phase_in      = PH_TEXT;
         nib_in        = '0;
         count_in      = '0;
         err_in        = 1'b0;
      end else if (!err_ff) begin
         unique case (phase_ff)
            PH_TEXT: begin
               if (in_char_ff == BACKSLASH) begin
                  phase_in = PH_ESC;
               end else begin
                  has_res     = 1'b1;
                  rsp_byte_in = in_char_ff;
                  rsp_bv_in   = 1'b1;
                  count_in    = count_inc;
               end
            end
            PH_ESC: begin
               if (in_char_ff == BACKSLASH) begin
                  phase_in    = PH_TEXT;
                  has_res     = 1'b1;
                  rsp_byte_in = BACKSLASH;
                  rsp_bv_in   = 1'b1;
                  count_in    = count_inc;
               end else if (hex.ok) begin
                  nib_in   = hex.nib;
                  phase_in = PH_HEX;
               end else begin
                  err_in   = 1'b1;
                  phase_in = PH_TEXT;
               end
            end
            PH_HEX: begin
               phase_in = PH_TEXT;
               nib_in   = '0;
               if (hex.ok) begin
                  has_res     = 1'b1;
                  rsp_byte_in = {nib_ff, hex.nib};
                  rsp_bv_in   = 1'b1;
                  count_in    = count_inc;
               end else begin
                  err_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_TEXT;
               nib_in   = '0;
               err_in   = 1'b1;
            end
         endcase
      end
   end

   // Response valid: loaded on a decode step, cleared once the response is transferred.
   always_comb begin
      if (proc) begin
         rsp_valid_in = has_res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_TEXT;
         nib_ff       <= '0;
         count_ff     <= '0;
         err_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc) begin
            phase_ff <= phase_in;
            nib_ff   <= nib_in;
            count_ff <= count_in;
            err_ff   <= err_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_kind_ff <= req_ch.kind;
         in_char_ff <= req_ch.char_code;
      end
      if (proc && has_res) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_bv_ff     <= rsp_bv_in;
         rsp_done_ff   <= rsp_done_in;
         rsp_status_ff <= rsp_status_in;
         rsp_len_ff    <= rsp_len_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_byte       = rsp_byte_ff;
   assign rsp_ch.byte_valid     = rsp_bv_ff;
   assign rsp_ch.done_res       = rsp_done_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.decoded_length = rsp_len_ff;

   // A character never wraps the length counter; it saturates instead.
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      proc && (in_kind_ff == KIND_CHAR) |-> count_in >= count_ff)
      else $error("length counter wrapped on a character");

   // A pending high nibble exists only while waiting for the second hex digit.
   a_nib_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_HEX |-> nib_ff == '0)
      else $error("stale high nibble outside the second-digit phase");

   // After a bad escape the decoder sits in plain-text phase until the end item.
   a_err_phase: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> phase_ff == PH_TEXT)
      else $error("escape phase active after a bad escape");

   // An empty response register never blocks the request side.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("request stalled with an empty response register");

   // A failing end response never reports a length.
   a_bad_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff && rsp_status_ff |-> rsp_len_ff == '0)
      else $error("length reported on a failing end response");

endmodule

@@ verif/backslash_hex_escape_decoder_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the backslash hex escape decoder: directed table, then random strings.
module backslash_hex_escape_decoder_tb;
   import bhed_pkg::*;

   localparam int COUNT_BITS    = COUNT_BITS_DEF;
   localparam int PHASE_ITEMS   = 55;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 80;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_byte;
      logic              byte_valid;
      logic              done_res;
      logic              status;
      logic [LEN_W-1:0]  decoded_length;
   } decoded_rsp_type;

   // One input character or end marker, optionally with its result typed in by hand.
   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] code;
      logic              fixed;
      logic              fixed_has;
      decoded_rsp_type   fixed_rsp;
   } text_item_type;

   localparam decoded_rsp_type NO_RSP    = '0;
   localparam decoded_rsp_type END_BAD   = '{8'h00, 1'b0, 1'b1, 1'b1, 13'd0};
   localparam decoded_rsp_type END_EMPTY = '{8'h00, 1'b0, 1'b1, 1'b0, 13'd0};

   // Characters just either side of the hex digit ranges.
   localparam logic [CHAR_W-1:0] NEAR_HEX [0:5] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

   // Directed rows; rows without a typed result are scored against the predictor.
   localparam text_item_type DIRECTED_ROWS [0:23] = '{
      '{KIND_CHAR, 8'h41,     1'b1, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0, 13'd0}},
      '{KIND_CHAR, 8'h00,     1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 13'd0}},
      '{KIND_CHAR, 8'hFF,     1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 13'd0}},
      '{KIND_CHAR, BACKSLASH, 1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, BACKSLASH, 1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, BACKSLASH, 1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, "f",       1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, "F",       1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, BACKSLASH, 1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, "0",       1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, "9",       1'b0, 1'b0, NO_RSP},
      '{KIND_END,  8'h00,     1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, BACKSLASH, 1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, "g",       1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, "A",       1'b1, 1'b0, NO_RSP},
      '{KIND_END,  8'h00,     1'b1, 1'b1, END_BAD},
      '{KIND_CHAR, BACKSLASH, 1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, "4",       1'b0, 1'b0, NO_RSP},
      '{KIND_END,  8'h00,     1'b1, 1'b1, END_BAD},
      '{KIND_CHAR, BACKSLASH, 1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, "5",       1'b0, 1'b0, NO_RSP},
      '{KIND_CHAR, "z",       1'b0, 1'b0, NO_RSP},
      '{KIND_END,  8'h00,     1'b1, 1'b1, END_BAD},
      '{KIND_END,  8'hFF,     1'b1, 1'b1, END_EMPTY}
   };

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   bhed_req_if req_ch();
   bhed_rsp_if rsp_ch();

   text_item_type   stim_q[$];
   text_item_type   sent_q[$];
   decoded_rsp_type expected_rsp[$];

   // Predictor copy of the decoder state and the length limit.
   logic [CFG_W-1:0]      max_len   = MAX_LEN_RESET;
   logic [1:0]            esc_phase = PH_TEXT;
   logic [NIB_W-1:0]      high_nib  = '0;
   logic [COUNT_BITS-1:0] byte_cnt  = '0;
   logic                  err_seen  = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int recv_hold      = 0;
   int errors         = 0;
   int n_items        = 0;
   int n_results      = 0;
   int n_done         = 0;
   int n_bad          = 0;
   int n_writes       = 0;

   backslash_hex_escape_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Works out the result of one character or end marker and advances the predictor state.
   task automatic decode_step(input logic kind, input logic [CHAR_W-1:0] c,
                              output logic has, output decoded_rsp_type r);
      logic                  is_hex;
      logic                  emit;
      logic [NIB_W-1:0]      nib;
      logic [CHAR_W-1:0]     b;
      logic [COUNT_BITS:0]   cap;
      has    = 1'b0;
      r      = '0;
      emit   = 1'b0;
      b      = c;
      is_hex = 1'b1;
      nib    = '0;
      if (c >= "0" && c <= "9")
         nib = c[3:0];
      else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
         nib = c[3:0] + 4'd9;
      else
         is_hex = 1'b0;

      if (kind == KIND_END) begin
         // An end marker always answers, then clears the string state.
         has              = 1'b1;
         r.done_res       = 1'b1;
         r.status         = err_seen || (esc_phase != PH_TEXT) || (byte_cnt > max_len);
         r.decoded_length = r.status ? '0 : byte_cnt;
         esc_phase        = PH_TEXT;
         high_nib         = '0;
         byte_cnt         = '0;
         err_seen         = 1'b0;
      end else if (!err_seen) begin
         case (esc_phase)
            PH_TEXT: begin
               if (c == BACKSLASH) esc_phase = PH_ESC;
               else emit = 1'b1;
            end
            PH_ESC: begin
               if (c == BACKSLASH) begin
                  esc_phase = PH_TEXT;
                  emit      = 1'b1;
               end else if (is_hex) begin
                  high_nib  = nib;
                  esc_phase = PH_HEX;
               end else begin
                  err_seen  = 1'b1;
                  esc_phase = PH_TEXT;
               end
            end
            default: begin
               if (esc_phase == PH_HEX && is_hex) begin
                  b    = {high_nib, nib};
                  emit = 1'b1;
               end else begin
                  err_seen = 1'b1;
               end
               esc_phase = PH_TEXT;
               high_nib  = '0;
            end
         endcase
      end

      // The count stops one above the limit, and never wraps.
      if (emit) begin
         cap = (COUNT_BITS+1)'(max_len) + (COUNT_BITS+1)'(1);
         if (cap > COUNT_MAX) cap = COUNT_MAX;
         if (byte_cnt < cap) byte_cnt = byte_cnt + 1'b1;
         has          = 1'b1;
         r.out_byte   = b;
         r.byte_valid = 1'b1;
      end
   endtask

   // Score every transfer on both channels.
   always @(posedge clock) begin : scoreboard
      text_item_type   sent;
      decoded_rsp_type want;
      decoded_rsp_type got;
      logic            has;
      if (!reset) begin
         if (csr_wr_en) max_len = csr_wr_data;
         if (req_ch.valid && req_ch.ready) begin
            sent = sent_q.pop_front();
            decode_step(req_ch.kind, req_ch.char_code, has, want);
            if (sent.fixed) begin
               has  = sent.fixed_has;
               want = sent.fixed_rsp;
            end
            if (has) expected_rsp.push_back(want);
            n_items++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.out_byte, rsp_ch.byte_valid, rsp_ch.done_res, rsp_ch.status,
                    rsp_ch.decoded_length};
            if (expected_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: byte %02h bv %b done %b status %b length %0d",
                        $time, got.out_byte, got.byte_valid, got.done_res, got.status,
                        got.decoded_length);
            end else begin
               want = expected_rsp.pop_front();
               n_results++;
               if (want.done_res) n_done++;
               if (want.done_res && want.status) n_bad++;
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch: expected byte %02h bv %b done %b status %b len %0d",
                           $time, want.out_byte, want.byte_valid, want.done_res,
                           want.status, want.decoded_length);
                  $display("%0t:             actual byte %02h bv %b done %b status %b len %0d",
                           $time, got.out_byte, got.byte_valid, got.done_res,
                           got.status, got.decoded_length);
               end
            end
         end
      end
   end

   // Result side: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (recv_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         recv_hold    <= recv_hold - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [CHAR_W-1:0] hex_char();
      int pick;
      pick = $urandom_range(21);
      if (pick < 10) return CHAR_W'("0" + pick);
      if (pick < 16) return CHAR_W'("A" + pick - 10);
      return CHAR_W'("a" + pick - 16);
   endfunction

   function automatic logic [CHAR_W-1:0] plain_char();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom_range(255)); while (c == BACKSLASH);
      return c;
   endfunction

   task automatic add_item(input logic kind, input logic [CHAR_W-1:0] code);
      stim_q.push_back('{kind, code, 1'b0, 1'b0, NO_RSP});
   endtask

   // Mostly well-formed strings of random tokens; the rest is noise rich in escapes.
   task automatic append_string();
      int   tokens;
      int   pick;
      logic broken;
      broken = ($urandom_range(99) < 20);
      tokens = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
      for (int i = 0; i < tokens; i++) begin
         pick = $urandom_range(9);
         if (broken) begin
            if (pick < 3) add_item(KIND_CHAR, hex_char());
            else if (pick < 5) add_item(KIND_CHAR, BACKSLASH);
            else if (pick < 6) add_item(KIND_CHAR, NEAR_HEX[$urandom_range(5)]);
            else add_item(KIND_CHAR, CHAR_W'($urandom_range(255)));
         end else if (pick < 6) begin
            add_item(KIND_CHAR, plain_char());
         end else if (pick < 7) begin
            add_item(KIND_CHAR, BACKSLASH);
            add_item(KIND_CHAR, BACKSLASH);
         end else begin
            add_item(KIND_CHAR, BACKSLASH);
            add_item(KIND_CHAR, hex_char());
            add_item(KIND_CHAR, hex_char());
         end
      end
      add_item(KIND_END, CHAR_W'($urandom_range(255)));
   endtask

   task automatic write_max_length(input logic [CFG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      n_writes++;
   endtask

   // Offer the queued items under the given idling pattern, then wait for the block to settle.
   task automatic run_phase(input idle_mode_type mode);
      text_item_type item;
      send_idle_pct   = (mode == IDLE_SEND) ? 55 : (mode == IDLE_BOTH) ? 27 : 0;
      recv_stall_pct <= (mode == IDLE_RECV) ? 55 : (mode == IDLE_BOTH) ? 27 : 0;
      while (stim_q.size() != 0) begin
         item = stim_q.pop_front();
         sent_q.push_back(item);
         while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid     <= 1'b1;
         req_ch.kind      <= item.kind;
         req_ch.char_code <= item.code;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
      end
      req_ch.valid <= 1'b0;
      // Quiet characters leave nothing to wait for, so allow the pipeline to empty too.
      do @(posedge clock); while (expected_rsp.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random phase; a phase may stop inside a string so the new limit lands mid-string.
   task automatic random_phase(input idle_mode_type mode, input logic [CFG_W-1:0] value,
                               input logic with_long, input logic with_hold);
      int target;
      write_max_length(value);
      if (with_long) begin
         // Strings of exactly the limit and one byte over it.
         for (int extra = 0; extra < 2; extra++) begin
            for (int i = 0; i < int'(value) + extra; i++) add_item(KIND_CHAR, plain_char());
            add_item(KIND_END, CHAR_W'($urandom_range(255)));
         end
      end
      target = stim_q.size() + PHASE_ITEMS;
      while (stim_q.size() < target) append_string();
      if ($urandom_range(99) < 40) void'(stim_q.pop_back());
      if (with_hold) recv_hold <= HOLD_CYCLES;
      run_phase(mode);
   endtask

   initial begin : stimulus
      // Known values on the request channel from time zero.
      req_ch.valid     = 1'b0;
      req_ch.kind      = KIND_CHAR;
      req_ch.char_code = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) stim_q.push_back(DIRECTED_ROWS[i]);
      run_phase(IDLE_NONE);

      random_phase(IDLE_NONE, '0, 1'b0, 1'b0);
      random_phase(IDLE_SEND, 12'd1, 1'b0, 1'b0);
      random_phase(IDLE_RECV, 12'd4, 1'b0, 1'b1);
      random_phase(IDLE_NONE, '1, 1'b0, 1'b0);
      random_phase(IDLE_BOTH, CFG_W'($urandom_range(60, 2)), 1'b0, 1'b0);
      random_phase(IDLE_SEND, MAX_LEN_RESET, 1'b0, 1'b0);
      random_phase(IDLE_RECV, CFG_W'($urandom_range(4095)), 1'b0, 1'b0);
      random_phase(IDLE_BOTH, 12'd12, 1'b1, 1'b1);

      $display("Sent %0d input transfers; checked %0d results, %0d of them end-of-string reports",
               n_items, n_results, n_done);
      $display("(%0d with error status), over %0d limit settings and four idling patterns.",
               n_bad, n_writes + 1);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Ends a hung run.
   initial begin : watchdog
      #5ms;
      $display("Timed out with %0d results still outstanding.", expected_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
